>>> src/msm_pkg.sv
// shared types, field widths and codes for the magic signature matcher
package msm_pkg;

  // default sizing handed to the top level
  localparam int MSM_MAX_FORMATS      = 8;
  localparam int MSM_MAX_ALTERNATIVES = 4;
  localparam int MSM_MAX_SPAN         = 16;

  // fixed field widths
  localparam int MODE_W   = 3;
  localparam int SLOT_W   = 3;
  localparam int ALT_W    = 2;
  localparam int POS_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int WOFF_W   = 4;
  localparam int WLEN_W   = 5;
  localparam int WCNT_W   = 3;
  localparam int STATUS_W = 2;
  localparam int FMT_ID_W = 3;
  localparam int FIU_W    = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_DESC = 3'd0,
    MODE_LOAD_SIG  = 3'd1,
    MODE_START     = 3'd2,
    MODE_DATA      = 3'd3,
    MODE_END       = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_RECOGNISED = 2'd0,
    STATUS_UNKNOWN    = 2'd1,
    STATUS_ENDED      = 2'd2
  } status_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] format_slot;
    logic [ALT_W-1:0]  alternative;
    logic [POS_W-1:0]  window_position;
    logic [BYTE_W-1:0] byte_value;
    logic [WOFF_W-1:0] window_offset;
    logic [WLEN_W-1:0] window_length;
    logic [WCNT_W-1:0] alternative_count;
  } item_t;

  typedef struct packed {
    status_t               status;
    logic [FMT_ID_W-1:0]   matched_format;
  } result_t;

endpackage

>>> src/msm_if.sv
// handshake channels for input items and result beats
interface msm_item_if;
  import msm_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [SLOT_W-1:0]   format_slot;
  logic [ALT_W-1:0]    alternative;
  logic [POS_W-1:0]    window_position;
  logic [BYTE_W-1:0]   byte_value;
  logic [WOFF_W-1:0]   window_offset;
  logic [WLEN_W-1:0]   window_length;
  logic [WCNT_W-1:0]   alternative_count;

  modport source (
    output valid, mode, format_slot, alternative, window_position, byte_value,
           window_offset, window_length, alternative_count,
    input  ready
  );
  modport sink (
    input  valid, mode, format_slot, alternative, window_position, byte_value,
           window_offset, window_length, alternative_count,
    output ready
  );
endinterface

interface msm_result_if;
  import msm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FMT_ID_W-1:0] matched_format;

  modport source (output valid, status, matched_format, input ready);
  modport sink   (input valid, status, matched_format, output ready);
endinterface

>>> src/magic_signature_matcher.sv
// top level: channels, formats register and the result output register
// Recognises a file's format from its leading bytes against up to MAX_FORMATS
// loaded descriptors, each with up to MAX_ALTERNATIVES signatures held in one
// signature ram. Descriptor loads, signature loads, file start, ignored modes
// and bytes after a decision are taken in the idle state and leave it there; an
// end of input on an undecided file goes to the result state to offer its beat.
// A data byte is accepted, then the sequencer takes a format step for each format
// in use and, when the byte falls inside that format's window, a compare step
// for each of its alternatives, and a result step when the byte gives a result.
// The walk is bounded by the single read port of the signature ram, which the
// sequencer walks one alternative per cycle. The result sits in an output
// register, so the next item is taken while a finished beat waits downstream.
module magic_signature_matcher #(
  parameter int MAX_FORMATS      = msm_pkg::MSM_MAX_FORMATS,
  parameter int MAX_ALTERNATIVES = msm_pkg::MSM_MAX_ALTERNATIVES,
  parameter int MAX_SPAN         = msm_pkg::MSM_MAX_SPAN
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [msm_pkg::FIU_W-1:0] cfg_wr_data,
  msm_item_if.sink                  item,
  msm_result_if.source              result
);
  import msm_pkg::*;

  logic [FIU_W-1:0] formats_in_use;
  item_t            item_data;
  result_t          res;
  logic             core_idle, res_valid, res_ack, item_accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      formats_in_use <= FIU_W'(1);
    end else if (cfg_wr_en) begin
      formats_in_use <= cfg_wr_data;
    end
  end

  assign item.ready  = core_idle;
  assign item_accept = item.valid && core_idle;

  assign item_data.mode              = item.mode;
  assign item_data.format_slot       = item.format_slot;
  assign item_data.alternative       = item.alternative;
  assign item_data.window_position   = item.window_position;
  assign item_data.byte_value        = item.byte_value;
  assign item_data.window_offset     = item.window_offset;
  assign item_data.window_length     = item.window_length;
  assign item_data.alternative_count = item.alternative_count;

  msm_core #(
    .MAX_FORMATS      (MAX_FORMATS),
    .MAX_ALTERNATIVES (MAX_ALTERNATIVES),
    .MAX_SPAN         (MAX_SPAN)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .item_accept    (item_accept),
    .item           (item_data),
    .formats_in_use (formats_in_use),
    .idle           (core_idle),
    .res_valid      (res_valid),
    .res            (res),
    .res_ack        (res_ack)
  );

  // output register: load when empty or being drained this cycle
  assign res_ack = res_valid && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_ack) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      result.status         <= res.status;
      result.matched_format <= res.matched_format;
    end
  end

endmodule

>>> src/msm_ram.sv
// generic simple dual-port ram with registered read
module msm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/msm_core.sv
// descriptor table, signature store and the sequencer that walks formats and alternatives
module msm_core #(
  parameter int MAX_FORMATS      = msm_pkg::MSM_MAX_FORMATS,
  parameter int MAX_ALTERNATIVES = msm_pkg::MSM_MAX_ALTERNATIVES,
  parameter int MAX_SPAN         = msm_pkg::MSM_MAX_SPAN
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_accept,
  input  msm_pkg::item_t               item,
  input  logic [msm_pkg::FIU_W-1:0]    formats_in_use,
  output logic                         idle,
  output logic                         res_valid,
  output msm_pkg::result_t             res,
  input  logic                         res_ack
);
  import msm_pkg::*;

  localparam int FMT_W  = (MAX_FORMATS > 1) ? $clog2(MAX_FORMATS) : 1;
  localparam int NUM_W  = $clog2(MAX_FORMATS + 1);
  localparam int OFF_W  = $clog2(MAX_SPAN);
  localparam int LEN_W  = $clog2(MAX_SPAN + 1);
  localparam int SUM_W  = LEN_W + 1;
  localparam int CNT_W  = $clog2(MAX_ALTERNATIVES + 1);
  localparam int DEPTH  = MAX_FORMATS * MAX_ALTERNATIVES * MAX_SPAN;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FMT  = 4'b0010,
    S_ALT  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                 state;
  logic                   decided;
  logic [LEN_W-1:0]       byte_counter;
  logic [MAX_FORMATS-1:0] still_matching;
  logic [NUM_W-1:0]       j;
  logic [CNT_W-1:0]       k;
  logic                   hit_acc;
  logic [SUM_W-1:0]       span_acc;
  logic [BYTE_W-1:0]      data_byte;

  logic [OFF_W-1:0] desc_off [MAX_FORMATS];
  logic [LEN_W-1:0] desc_len [MAX_FORMATS];
  logic [CNT_W-1:0] desc_cnt [MAX_FORMATS];

  // descriptor load with window clipping
  logic [31:0] w_off, w_len, w_cnt;
  logic        desc_we;

  always_comb begin
    w_off = 32'(item.window_offset);
    if (w_off > 32'(MAX_SPAN) - 32'd1) w_off = 32'(MAX_SPAN) - 32'd1;
    w_len = 32'(item.window_length);
    if (w_len < 32'd1) w_len = 32'd1;
    if (w_len > 32'(MAX_SPAN) - w_off) w_len = 32'(MAX_SPAN) - w_off;
    w_cnt = 32'(item.alternative_count);
    if (w_cnt > 32'(MAX_ALTERNATIVES)) w_cnt = 32'(MAX_ALTERNATIVES);
  end

  assign desc_we = item_accept && (item.mode == MODE_LOAD_DESC) &&
                   (32'(item.format_slot) < 32'(MAX_FORMATS));

  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_off[FMT_W'(item.format_slot)] <= OFF_W'(w_off);
      desc_len[FMT_W'(item.format_slot)] <= LEN_W'(w_len);
      desc_cnt[FMT_W'(item.format_slot)] <= CNT_W'(w_cnt);
    end
  end

  // signature store
  logic              sig_we;
  logic [ADDR_W-1:0] sig_waddr, sig_raddr;
  logic [BYTE_W-1:0] sig_rdata;

  assign sig_we = item_accept && (item.mode == MODE_LOAD_SIG) &&
                  (32'(item.format_slot) < 32'(MAX_FORMATS)) &&
                  (32'(item.alternative) < 32'(MAX_ALTERNATIVES)) &&
                  (32'(item.window_position) < 32'(MAX_SPAN));
  assign sig_waddr = ADDR_W'((32'(item.format_slot) * 32'(MAX_ALTERNATIVES) +
                              32'(item.alternative)) * 32'(MAX_SPAN) +
                             32'(item.window_position));

  msm_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_sig_ram (
    .clk   (clk),
    .we    (sig_we),
    .waddr (sig_waddr),
    .wdata (item.byte_value),
    .raddr (sig_raddr),
    .rdata (sig_rdata)
  );

  // per-format evaluation
  logic [NUM_W-1:0] n_act;
  logic [FMT_W-1:0] jx;
  logic [OFF_W-1:0] cur_off;
  logic [CNT_W-1:0] cur_cnt;
  logic [SUM_W-1:0] cur_end, ctr_ext, ctr_inc, span_now;
  logic [OFF_W-1:0] rel_pos;
  logic [CNT_W-1:0] k_sel;
  logic             in_win, hit_now, last_alt, fin, miss, keep, closes, last_fmt;

  always_comb begin
    if (formats_in_use == '0) begin
      n_act = NUM_W'(1);
    end else if (32'(formats_in_use) > 32'(MAX_FORMATS)) begin
      n_act = NUM_W'(MAX_FORMATS);
    end else begin
      n_act = NUM_W'(formats_in_use);
    end
  end

  assign jx       = j[FMT_W-1:0];
  assign cur_off  = desc_off[jx];
  assign cur_cnt  = desc_cnt[jx];
  assign cur_end  = SUM_W'(cur_off) + SUM_W'(desc_len[jx]);
  assign ctr_ext  = SUM_W'(byte_counter);
  assign ctr_inc  = ctr_ext + SUM_W'(1);
  assign in_win   = (ctr_ext >= SUM_W'(cur_off)) && (ctr_ext < cur_end);
  assign rel_pos  = OFF_W'(ctr_ext - SUM_W'(cur_off));
  assign span_now = (cur_end > span_acc) ? cur_end : span_acc;

  // alternative 0 is fetched from the format step, the next one while comparing
  assign k_sel     = (state == S_ALT) ? k + CNT_W'(1) : '0;
  assign sig_raddr = ADDR_W'((32'(jx) * 32'(MAX_ALTERNATIVES) + 32'(k_sel)) *
                             32'(MAX_SPAN) + 32'(rel_pos));

  assign hit_now  = hit_acc || (sig_rdata == data_byte);
  assign last_alt = (32'(k) + 32'd1) >= 32'(cur_cnt);

  always_comb begin
    fin  = 1'b0;
    miss = 1'b0;
    unique case (state)
      S_FMT: begin
        fin  = !(in_win && (cur_cnt != '0));
        miss = in_win;
      end
      S_ALT: begin
        fin  = last_alt;
        miss = !hit_now;
      end
      default: begin
        fin  = 1'b0;
        miss = 1'b0;
      end
    endcase
  end

  assign keep     = still_matching[jx] && !miss;
  assign closes   = (ctr_inc == cur_end) && keep;
  assign last_fmt = (32'(j) + 32'd1) == 32'(n_act);

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      decided        <= 1'b1;
      byte_counter   <= '0;
      still_matching <= '1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_accept) begin
            unique case (item.mode)
              MODE_START: begin
                byte_counter   <= '0;
                still_matching <= '1;
                decided        <= 1'b0;
              end
              MODE_DATA: begin
                if (!decided) begin
                  j         <= '0;
                  span_acc  <= '0;
                  data_byte <= item.byte_value;
                  state     <= S_FMT;
                end
              end
              MODE_END: begin
                if (!decided) begin
                  decided            <= 1'b1;
                  res.status         <= STATUS_ENDED;
                  res.matched_format <= '0;
                  state              <= S_EMIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FMT, S_ALT: begin
          if (state == S_FMT) begin
            span_acc <= span_now;
          end
          if (fin) begin
            still_matching[jx] <= keep;
            hit_acc            <= 1'b0;
            if (closes) begin
              decided            <= 1'b1;
              res.status         <= STATUS_RECOGNISED;
              res.matched_format <= FMT_ID_W'(j);
              state              <= S_EMIT;
            end else if (last_fmt) begin
              byte_counter <= LEN_W'(ctr_inc);
              if (ctr_inc >= span_now) begin
                decided            <= 1'b1;
                res.status         <= STATUS_UNKNOWN;
                res.matched_format <= '0;
                state              <= S_EMIT;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              j     <= j + NUM_W'(1);
              state <= S_FMT;
            end
          end else if (state == S_FMT) begin
            k       <= '0;
            hit_acc <= 1'b0;
            state   <= S_ALT;
          end else begin
            k       <= k + CNT_W'(1);
            hit_acc <= hit_now;
          end
        end
        S_EMIT: begin
          if (res_ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // the alternative walk stays inside the format's alternative count
  a_alt_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALT) |-> (32'(k) < 32'(cur_cnt)))
    else $error("alternative index beyond descriptor count");

  // the format walk stays inside the formats in use
  a_fmt_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FMT || state == S_ALT) |-> (32'(j) < 32'(n_act)))
    else $error("format index beyond formats in use");

  // any report leaves the file decided
  a_report_decides: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> decided)
    else $error("result pending while file still undecided");

  // an undecided data byte starts the format walk
  a_data_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (item_accept && (item.mode == MODE_DATA) && !decided) |=> (state == S_FMT))
    else $error("data byte did not start the format walk");
`endif

endmodule
